### rtl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg
// Shared types and constants of the air sensor frame parser: frame layout,
// header codes, queue depth and the request classes passed front to back.
// ----------------------------------------------------------------------------
package afp_pkg;

   // Frame header codes
   localparam logic [7:0] HDR_FIRST  = 8'h42;
   localparam logic [7:0] HDR_SECOND = 8'h4D;

   // Supported length field values
   localparam logic [15:0] LEN_SHORT = 16'(2 * 9 + 2);
   localparam logic [15:0] LEN_LONG  = 16'(2 * 13 + 2);

   // Number of data bytes kept for the result words
   localparam int PAYLOAD_BYTES = 14;
   localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

   // Byte position within a frame
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_HDR_FIRST  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR_SECOND = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN_HI     = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LEN_LO     = POS_W'(3);
   localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(4);
   localparam logic [POS_W-1:0] POS_SUM_HI_SHORT = POS_W'(LEN_SHORT + 16'd2);
   localparam logic [POS_W-1:0] POS_SUM_LO_SHORT = POS_W'(LEN_SHORT + 16'd3);
   localparam logic [POS_W-1:0] POS_SUM_HI_LONG  = POS_W'(LEN_LONG + 16'd2);
   localparam logic [POS_W-1:0] POS_SUM_LO_LONG  = POS_W'(LEN_LONG + 16'd3);

   // Payload byte index of the high byte of each result word
   localparam int IDX_PM25     = 0;
   localparam int IDX_TVOC     = 2;
   localparam int IDX_HCHO     = 5;
   localparam int IDX_CO2      = 8;
   localparam int IDX_TEMP     = 10;
   localparam int IDX_HUMIDITY = 12;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request classes decided by the front
   typedef enum logic [2:0] {
      KIND_START,    // first header byte, restarts the sum
      KIND_ADD,      // add to the sum only
      KIND_STORE,    // add to the sum and keep in the payload store
      KIND_SUM_HI,   // high checksum byte
      KIND_SUM_LO    // low checksum byte, closes the frame
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [IDX_W-1:0] idx;
   } item_type;

endpackage

### rtl/air_sensor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// air_sensor_frame_parser_top
// Frame parser for an air-quality sensor's serial byte stream.
//
// Request channel: one received byte per request (req_valid, req_stall,
// req_rx_byte). Bytes are matched against the header 0x42 0x4D, a big-endian
// length of 20 or 28, the data bytes and a big-endian 16-bit checksum;
// anything outside a frame is dropped without a response.
// Response channel: one response per complete frame, raised after the last
// checksum byte, with rsp_frame_ok and six big-endian words (all zero when
// the checksum does not match).
// Throughput: one byte per cycle while req_stall is low. The last checksum
// byte is written into the queue; once it reaches the head with the response
// side free, it is popped and the response valid register is set.
// A two-entry queue sits between the byte classifier and the checksum/result
// unit. While a response waits under rsp_stall, the next frame's bytes keep
// flowing until the following frame end reaches the head of the queue; the
// queue then fills and req_stall rises.
// Reset clears frame tracking, the queue and response valid; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module air_sensor_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_pm25_ug_m3,
   output logic [15:0] rsp_tvoc_centi_ppm,
   output logic [15:0] rsp_hcho_centi_mgm3,
   output logic [15:0] rsp_co2_ppm,
   output logic [15:0] rsp_temp_deci,
   output logic [15:0] rsp_humidity_deci
);
   import afp_pkg::*;

   item_type push_item;
   item_type head;
   logic     push;
   logic     pop;
   logic     q_empty;
   logic     q_full;

   assign req_stall = q_full;

   // Classify incoming bytes
   afp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .item        (push_item)
   );

   // Decouple classifier from result unit
   afp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Sum, store and report
   afp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (q_empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_pm25_ug_m3      (rsp_pm25_ug_m3),
      .rsp_tvoc_centi_ppm  (rsp_tvoc_centi_ppm),
      .rsp_hcho_centi_mgm3 (rsp_hcho_centi_mgm3),
      .rsp_co2_ppm         (rsp_co2_ppm),
      .rsp_temp_deci       (rsp_temp_deci),
      .rsp_humidity_deci   (rsp_humidity_deci)
   );

endmodule

### rtl/afp_front.sv
// ----------------------------------------------------------------------------
// afp_front
// Accepts received bytes, tracks the frame position and length, drops bytes
// that do not belong to a frame and classifies the rest for the back end.
// ----------------------------------------------------------------------------
module afp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_rx_byte,
   input  logic               q_full,
   output logic               push,
   output afp_pkg::item_type  item
);
   import afp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic             long_ff, long_in;
   logic [POS_W-1:0] data_idx;
   logic [POS_W-1:0] sum_hi_pos;
   logic [POS_W-1:0] sum_lo_pos;
   logic [15:0]      len_word;
   logic             accept;

   assign accept     = req_valid && !q_full;
   assign data_idx   = pos_ff - POS_DATA_FIRST;
   assign sum_hi_pos = long_ff ? POS_SUM_HI_LONG : POS_SUM_HI_SHORT;
   assign sum_lo_pos = long_ff ? POS_SUM_LO_LONG : POS_SUM_LO_SHORT;
   assign len_word   = {len_hi_ff, req_rx_byte};

   // Classify the byte and advance the position
   always_comb begin
      pos_in    = pos_ff;
      len_hi_in = len_hi_ff;
      long_in   = long_ff;
      push      = 1'b0;
      item.kind = KIND_ADD;
      item.data = req_rx_byte;
      item.idx  = data_idx[IDX_W-1:0];
      if (accept) begin
         if (pos_ff == POS_HDR_FIRST) begin
            if (req_rx_byte == HDR_FIRST) begin
               push      = 1'b1;
               item.kind = KIND_START;
               pos_in    = POS_HDR_SECOND;
            end
         end else if (pos_ff == POS_HDR_SECOND) begin
            if (req_rx_byte == HDR_SECOND) begin
               push   = 1'b1;
               pos_in = POS_LEN_HI;
            end else begin
               pos_in = POS_HDR_FIRST;
            end
         end else if (pos_ff == POS_LEN_HI) begin
            push      = 1'b1;
            len_hi_in = req_rx_byte;
            pos_in    = POS_LEN_LO;
         end else if (pos_ff == POS_LEN_LO) begin
            if (len_word == LEN_SHORT || len_word == LEN_LONG) begin
               push    = 1'b1;
               long_in = (len_word == LEN_LONG);
               pos_in  = POS_DATA_FIRST;
            end else begin
               pos_in = POS_HDR_FIRST;
            end
         end else if (pos_ff == sum_hi_pos) begin
            push      = 1'b1;
            item.kind = KIND_SUM_HI;
            pos_in    = pos_ff + POS_W'(1);
         end else if (pos_ff == sum_lo_pos) begin
            push      = 1'b1;
            item.kind = KIND_SUM_LO;
            pos_in    = POS_HDR_FIRST;
         end else begin
            push      = 1'b1;
            item.kind = (data_idx < POS_W'(PAYLOAD_BYTES)) ? KIND_STORE : KIND_ADD;
            pos_in    = pos_ff + POS_W'(1);
         end
      end
   end

   // Hold frame position and length
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HDR_FIRST;
         len_hi_ff <= 8'd0;
         long_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         len_hi_ff <= len_hi_in;
         long_ff   <= long_in;
      end
   end

endmodule

### rtl/afp_queue.sv
// ----------------------------------------------------------------------------
// afp_queue
// Short first-in first-out queue of classified requests between the front
// and the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module afp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  afp_pkg::item_type  push_item,
   input  logic               pop,
   output afp_pkg::item_type  head,
   output logic               empty,
   output logic               full
);
   import afp_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign empty   = (count_ff == QCNT_W'(0));
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Advance pointers with explicit wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                              : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                              : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/afp_back.sv
// ----------------------------------------------------------------------------
// afp_back
// Carries out classified requests: keeps the running checksum and payload
// bytes, compares the checksum at frame end and holds the result register.
// ----------------------------------------------------------------------------
module afp_back (
   input  logic               clock,
   input  logic               reset,
   input  afp_pkg::item_type  head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_ok,
   output logic [15:0]        rsp_pm25_ug_m3,
   output logic [15:0]        rsp_tvoc_centi_ppm,
   output logic [15:0]        rsp_hcho_centi_mgm3,
   output logic [15:0]        rsp_co2_ppm,
   output logic [15:0]        rsp_temp_deci,
   output logic [15:0]        rsp_humidity_deci
);
   import afp_pkg::*;

   logic [15:0] sum_ff, sum_in;
   logic [7:0]  rx_sum_hi_ff;
   logic [7:0]  store_ff [PAYLOAD_BYTES];
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff;
   logic [15:0] pm25_ff, tvoc_ff, hcho_ff, co2_ff, temp_ff, hum_ff;
   logic        out_free;
   logic        close;
   logic        ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !empty && ((head.kind != KIND_SUM_LO) || out_free);
   assign close    = pop && (head.kind == KIND_SUM_LO);
   assign ok       = (sum_ff == {rx_sum_hi_ff, head.data});

   // Update the running sum
   always_comb begin
      sum_in = sum_ff;
      if (pop) begin
         case (head.kind) inside
            KIND_START:            sum_in = {8'd0, head.data};
            KIND_ADD, KIND_STORE:  sum_in = sum_ff + {8'd0, head.data};
            default:               sum_in = sum_ff;
         endcase
      end
   end

   // Raise valid at frame end, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (close) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Keep checksum high byte and payload bytes
   always_ff @(posedge clock) begin
      if (pop && head.kind == KIND_SUM_HI) begin
         rx_sum_hi_ff <= head.data;
      end
      if (pop && head.kind == KIND_STORE) begin
         store_ff[head.idx] <= head.data;
      end
   end

   // Load the result words, zero on checksum mismatch
   always_ff @(posedge clock) begin
      if (close) begin
         ok_ff   <= ok;
         pm25_ff <= ok ? {store_ff[IDX_PM25], store_ff[IDX_PM25 + 1]} : 16'd0;
         tvoc_ff <= ok ? {store_ff[IDX_TVOC], store_ff[IDX_TVOC + 1]} : 16'd0;
         hcho_ff <= ok ? {store_ff[IDX_HCHO], store_ff[IDX_HCHO + 1]} : 16'd0;
         co2_ff  <= ok ? {store_ff[IDX_CO2], store_ff[IDX_CO2 + 1]} : 16'd0;
         temp_ff <= ok ? {store_ff[IDX_TEMP], store_ff[IDX_TEMP + 1]} : 16'd0;
         hum_ff  <= ok ? {store_ff[IDX_HUMIDITY], store_ff[IDX_HUMIDITY + 1]} : 16'd0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = ok_ff;
   assign rsp_pm25_ug_m3      = pm25_ff;
   assign rsp_tvoc_centi_ppm  = tvoc_ff;
   assign rsp_hcho_centi_mgm3 = hcho_ff;
   assign rsp_co2_ppm         = co2_ff;
   assign rsp_temp_deci       = temp_ff;
   assign rsp_humidity_deci   = hum_ff;

endmodule

### rtl/afp_checker.sv
// ----------------------------------------------------------------------------
// afp_checker
// Port-level checks on the frame parser: reset behaviour, response hold
// under stall and zeroed words on checksum mismatch.
// ----------------------------------------------------------------------------
module afp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_ok,
   input logic [15:0] rsp_pm25_ug_m3,
   input logic [15:0] rsp_tvoc_centi_ppm,
   input logic [15:0] rsp_hcho_centi_mgm3,
   input logic [15:0] rsp_co2_ppm,
   input logic [15:0] rsp_temp_deci,
   input logic [15:0] rsp_humidity_deci
);

   // Reset drops any pending response and releases the request side
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response valid or request stall after reset");

   // Hold a stalled response
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_ok)
         && $stable(rsp_pm25_ug_m3) && $stable(rsp_tvoc_centi_ppm)
         && $stable(rsp_hcho_centi_mgm3) && $stable(rsp_co2_ppm)
         && $stable(rsp_temp_deci) && $stable(rsp_humidity_deci)))
      else $error("stalled response changed");

   // Mismatched frame reports all words as zero
   a_bad_frame_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ok) |-> (rsp_pm25_ug_m3 == 16'd0
         && rsp_tvoc_centi_ppm == 16'd0 && rsp_hcho_centi_mgm3 == 16'd0
         && rsp_co2_ppm == 16'd0 && rsp_temp_deci == 16'd0
         && rsp_humidity_deci == 16'd0))
      else $error("non-zero word on checksum mismatch");

   // Request stall only arises behind a stalled response
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without stalled response");

endmodule

bind air_sensor_frame_parser_top afp_checker u_afp_checker (.*);

### test/sensor_frame_check_pkg.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_pkg
// Expected-reading tracker for the air sensor frame parser bench: follows the
// received byte stream the way the parser must, queues the reading each
// frame end should produce and compares the parser's responses against it.
// ----------------------------------------------------------------------------
package sensor_frame_check_pkg;

   import afp_pkg::*;

   // One response of the parser
   typedef struct {
      logic        ok;
      logic [15:0] pm25;
      logic [15:0] tvoc;
      logic [15:0] hcho;
      logic [15:0] co2;
      logic [15:0] temp;
      logic [15:0] humidity;
   } sensor_reading_type;

   class frame_predictor;

      logic [POS_W-1:0]   position;
      logic [15:0]        frame_len;
      logic [15:0]        byte_sum;
      logic [15:0]        sent_sum;
      logic [7:0]         payload [PAYLOAD_BYTES];
      sensor_reading_type expected_readings [$];
      int                 readings_predicted;
      int                 mismatches;

      function new();
         position           = POS_HDR_FIRST;
         frame_len          = '0;
         byte_sum           = '0;
         sent_sum           = '0;
         readings_predicted = 0;
         mismatches         = 0;
         foreach (payload[i]) payload[i] = '0;
      endfunction

      function logic [15:0] payload_word(int hi);
         return {payload[hi], payload[hi+1]};
      endfunction

      // Advance the frame tracking by one accepted request byte
      function void accept_byte(logic [7:0] rx);
         sensor_reading_type r;
         int                 idx;
         if (position == POS_HDR_FIRST) begin
            if (rx != HDR_FIRST) return;
            byte_sum = 16'(rx);
         end else if (position == POS_HDR_SECOND) begin
            // a wrong second byte is not retried as a first header byte
            if (rx != HDR_SECOND) begin
               position = POS_HDR_FIRST;
               return;
            end
            byte_sum = byte_sum + 16'(rx);
         end else if (position == POS_LEN_HI) begin
            byte_sum  = byte_sum + 16'(rx);
            frame_len = {rx, 8'h00};
         end else if (position == POS_LEN_LO) begin
            // drop unsupported lengths before the low byte reaches the sum
            frame_len = {frame_len[15:8], rx};
            if (frame_len != LEN_SHORT && frame_len != LEN_LONG) begin
               position = POS_HDR_FIRST;
               return;
            end
            byte_sum = byte_sum + 16'(rx);
         end else if (int'(position) == int'(frame_len) + 2) begin
            sent_sum = {rx, 8'h00};
         end else if (int'(position) == int'(frame_len) + 3) begin
            // close the frame: words only when the checksum matches
            sent_sum = {sent_sum[15:8], rx};
            r.ok       = (byte_sum == sent_sum);
            r.pm25     = r.ok ? payload_word(IDX_PM25) : 16'h0000;
            r.tvoc     = r.ok ? payload_word(IDX_TVOC) : 16'h0000;
            r.hcho     = r.ok ? payload_word(IDX_HCHO) : 16'h0000;
            r.co2      = r.ok ? payload_word(IDX_CO2) : 16'h0000;
            r.temp     = r.ok ? payload_word(IDX_TEMP) : 16'h0000;
            r.humidity = r.ok ? payload_word(IDX_HUMIDITY) : 16'h0000;
            expected_readings.push_back(r);
            readings_predicted++;
            position = POS_HDR_FIRST;
            return;
         end else begin
            byte_sum = byte_sum + 16'(rx);
            idx      = int'(position) - int'(POS_DATA_FIRST);
            if (idx < PAYLOAD_BYTES) payload[idx] = rx;
         end
         position = position + 1'b1;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            mismatches++;
         end
      endfunction

      // Match one response against the oldest outstanding reading
      function void check_reading(sensor_reading_type got);
         sensor_reading_type want;
         if (expected_readings.size() == 0) begin
            $error("response with no reading outstanding");
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         compare_field("frame_ok", 16'(want.ok), 16'(got.ok));
         compare_field("pm25_ug_m3", want.pm25, got.pm25);
         compare_field("tvoc_centi_ppm", want.tvoc, got.tvoc);
         compare_field("hcho_centi_mgm3", want.hcho, got.hcho);
         compare_field("co2_ppm", want.co2, got.co2);
         compare_field("temp_deci", want.temp, got.temp);
         compare_field("humidity_deci", want.humidity, got.humidity);
      endfunction

   endclass

endpackage

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the air sensor frame parser. Feeds directed byte sequences (noise,
// broken headers, unsupported lengths, extreme payloads, bad checksums) and
// then a long mix of random frames, truncated frames and noise, with random
// gaps on the request side and random stalls on the response side. Every
// response is checked field by field against the tracked expected reading.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import afp_pkg::*;
   import sensor_frame_check_pkg::*;

   localparam int IDLE_PERCENT   = 15;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_BYTES   = 1100;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_frame_ok;
   logic [15:0] rsp_pm25_ug_m3;
   logic [15:0] rsp_tvoc_centi_ppm;
   logic [15:0] rsp_hcho_centi_mgm3;
   logic [15:0] rsp_co2_ppm;
   logic [15:0] rsp_temp_deci;
   logic [15:0] rsp_humidity_deci;

   // set while neither side may idle
   bit             steady     = 1'b0;
   int             frame_bytes = 0;
   int             quiet_cycles = 0;
   frame_predictor predictor  = new();

   air_sensor_frame_parser_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_pm25_ug_m3      (rsp_pm25_ug_m3),
      .rsp_tvoc_centi_ppm  (rsp_tvoc_centi_ppm),
      .rsp_hcho_centi_mgm3 (rsp_hcho_centi_mgm3),
      .rsp_co2_ppm         (rsp_co2_ppm),
      .rsp_temp_deci       (rsp_temp_deci),
      .rsp_humidity_deci   (rsp_humidity_deci)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the response side at random outside the steady stretch
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // Check each accepted response
   always @(posedge clock) begin
      sensor_reading_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.ok       = rsp_frame_ok;
         got.pm25     = rsp_pm25_ug_m3;
         got.tvoc     = rsp_tvoc_centi_ppm;
         got.hcho     = rsp_hcho_centi_mgm3;
         got.co2      = rsp_co2_ppm;
         got.temp     = rsp_temp_deci;
         got.humidity = rsp_humidity_deci;
         predictor.check_reading(got);
      end
   end

   // End the run when neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request byte and hold it until accepted
   task automatic push_byte(input logic [7:0] rx);
      while (!steady && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      predictor.accept_byte(rx);
      @(negedge clock);
   endtask

   // Build a frame (fill < 0 gives random data) and send its first cut bytes
   task automatic send_frame(input logic [15:0] len_field, input logic [15:0] sum_flip,
                             input int fill, input int cut);
      logic [7:0]  frame [$];
      logic [15:0] total;
      int          n_data;
      int          n_sent;
      frame = {HDR_FIRST, HDR_SECOND, len_field[15:8], len_field[7:0]};
      if (len_field == LEN_SHORT || len_field == LEN_LONG)
         n_data = int'(len_field) - 2;
      else
         n_data = $urandom_range(0, 6);
      for (int i = 0; i < n_data; i++)
         frame.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      total = '0;
      foreach (frame[i]) total = total + 16'(frame[i]);
      total = total ^ sum_flip;
      frame.push_back(total[15:8]);
      frame.push_back(total[7:0]);
      n_sent = (cut < 0 || cut > frame.size()) ? frame.size() : cut;
      for (int i = 0; i < n_sent; i++) push_byte(frame[i]);
      frame_bytes += n_sent;
   endtask

   initial begin
      int          frame_no;
      int          pick;
      int          fill;
      int          n_noise;
      logic [15:0] len;
      logic [15:0] bad_len;
      logic [7:0]  second;

      // Hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: noise while hunting, broken header, unsupported lengths
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(HDR_SECOND);
      push_byte(HDR_FIRST);
      push_byte(HDR_FIRST);
      push_byte(HDR_SECOND);
      push_byte(8'h00);
      send_frame(LEN_SHORT + 16'd1, 16'h0000, 0, 4);
      send_frame({8'h01, LEN_SHORT[7:0]}, 16'h0000, 0, 4);
      // Directed: extreme payloads, bad checksums and a frame cut short
      send_frame(LEN_SHORT, 16'h0000, 255, -1);
      send_frame(LEN_LONG, 16'h0000, 0, -1);
      send_frame(LEN_LONG, 16'h0000, 255, -1);
      send_frame(LEN_SHORT, 16'h8000, -1, -1);
      send_frame(LEN_LONG, 16'h0001, -1, -1);
      send_frame(LEN_SHORT, 16'h0000, -1, 10);
      send_frame(LEN_SHORT, 16'h0000, -1, -1);

      // Random: mostly well-formed frames, the rest broken sequences and noise
      frame_bytes = 0;
      frame_no    = 0;
      while (frame_bytes < RANDOM_BYTES) begin
         steady = (frame_no >= 12) && (frame_no < 27);
         pick   = $urandom_range(0, 99);
         len    = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
         fill   = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : -1;
         if (pick < 70) begin
            send_frame(len, 16'h0000, fill, -1);
         end else if (pick < 78) begin
            send_frame(len, 16'($urandom_range(1, 65535)), -1, -1);
         end else if (pick < 84) begin
            bad_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                           : len ^ (16'h0001 << $urandom_range(0, 15));
            if (bad_len == LEN_SHORT || bad_len == LEN_LONG) bad_len = bad_len ^ 16'h0100;
            send_frame(bad_len, 16'h0000, -1, -1);
         end else if (pick < 89) begin
            second = 8'($urandom_range(0, 255));
            if (second == HDR_SECOND) second = HDR_FIRST;
            push_byte(HDR_FIRST);
            push_byte(second);
            frame_bytes += 2;
         end else if (pick < 94) begin
            send_frame(len, 16'h0000, -1, $urandom_range(1, int'(len) + 3));
         end else begin
            n_noise = $urandom_range(1, 8);
            repeat (n_noise) push_byte(8'($urandom_range(0, 255)));
            frame_bytes += n_noise;
         end
         frame_no++;
      end
      steady    = 1'b0;
      req_valid <= 1'b0;

      // Drain outstanding readings, then allow the pipeline to settle
      while (predictor.expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (predictor.mismatches == 0 && predictor.expected_readings.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
